// ----- hw/rtl/ercb_pkg.sv -----
// Package for the error-rate circuit breaker: payload types, register map, codes.
// No dependencies.
package ercb_pkg;

    localparam int ENTRIES_DEF     = 16;
    localparam int MAX_BUCKETS_DEF = 16;

    localparam logic [1:0] ST_CLOSED = 2'd0;
    localparam logic [1:0] ST_OPEN   = 2'd1;
    localparam logic [1:0] ST_HALF   = 2'd2;

    localparam logic CMD_RECORD   = 1'b0;
    localparam logic CMD_EVALUATE = 1'b1;

    localparam logic [2:0] REG_VOLUME  = 3'd0;
    localparam logic [2:0] REG_RATE    = 3'd1;
    localparam logic [2:0] REG_BMS     = 3'd2;
    localparam logic [2:0] REG_BCOUNT  = 3'd3;
    localparam logic [2:0] REG_SLEEP   = 3'd4;
    localparam logic [2:0] REG_PREQ    = 3'd5;
    localparam logic [2:0] REG_PSUCC   = 3'd6;
    localparam logic [2:0] REG_EXPIRY  = 3'd7;

    localparam logic [15:0] SAT16       = 16'hFFFF;
    localparam logic [6:0]  IDLE_FACTOR = 7'd100;

    typedef struct packed {
        logic        command;
        logic [3:0]  instance_index;
        logic [47:0] now_ms;
        logic        call_failed;
        logic        half_open_enabled;
    } req_t;

    typedef struct packed {
        logic [1:0]  breaker_state;
        logic        state_changed;
        logic        entry_expired;
        logic [15:0] window_total;
        logic [15:0] window_errors;
    } rsp_t;

endpackage

// ----- hw/rtl/ercb_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ercb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hw/rtl/error_rate_circuit_breaker_unit.sv -----
// Error-rate circuit breaker: entry table and bucket rings in RAM, sequencer.
// Depends on ercb_pkg and ercb_ram.
// Sequence per request: 48-step division of now_ms by bucket_ms, a restoring
// division of the quotient by the bucket count for the bucket slot, then each
// bucket in the window in use read and summed, then the decision and the result.
// One request at a time: the next request is accepted only after the result is taken.
// Reset: registers to defaults, entry valid and bucket valid bits cleared
// at once; no clearing pass.
module error_rate_circuit_breaker_unit
    import ercb_pkg::*;
#(
    parameter int ENTRIES     = ENTRIES_DEF,
    parameter int MAX_BUCKETS = MAX_BUCKETS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  req_t        in_req,
    output logic        out_valid,
    input  logic        out_stall,
    output rsp_t        out_rsp
);
    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int NB = ENTRIES * MAX_BUCKETS;
    localparam int KW = (NB > 1) ? $clog2(NB) : 1;
    localparam int CW = $clog2(MAX_BUCKETS + 1);
    localparam int BDW = 48 + 16 + 16;

    localparam logic [3:0] S_IDLE = 4'd0, S_DIV = 4'd1, S_MOD = 4'd2,
        S_RDE = 4'd3, S_ENT = 4'd4, S_REC = 4'd5, S_SUM = 4'd6, S_SUMW = 4'd7,
        S_DEC = 4'd8, S_DEC2 = 4'd9, S_OUT = 4'd10;

    // configuration
    logic [15:0] vol_reg, rate_reg, bms_reg;
    logic [4:0]  bcnt_reg;
    logic [23:0] sleep_reg;
    logic [7:0]  preq_reg, psucc_reg;
    logic [31:0] exp_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_reg <= 16'd10; rate_reg <= 16'd32768; bms_reg <= 16'd1000;
            bcnt_reg <= 5'd10; sleep_reg <= 24'd30000; preq_reg <= 8'd10;
            psucc_reg <= 8'd8; exp_reg <= 32'd3600000;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[4:2])
                REG_VOLUME: vol_reg   <= pwdata[15:0];
                REG_RATE:   rate_reg  <= pwdata[15:0];
                REG_BMS:    bms_reg   <= pwdata[15:0];
                REG_BCOUNT: bcnt_reg  <= pwdata[4:0];
                REG_SLEEP:  sleep_reg <= pwdata[23:0];
                REG_PREQ:   preq_reg  <= pwdata[7:0];
                REG_PSUCC:  psucc_reg <= pwdata[7:0];
                REG_EXPIRY: exp_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_VOLUME: prdata = {16'd0, vol_reg};
            REG_RATE:   prdata = {16'd0, rate_reg};
            REG_BMS:    prdata = {16'd0, bms_reg};
            REG_BCOUNT: prdata = {27'd0, bcnt_reg};
            REG_SLEEP:  prdata = {8'd0, sleep_reg};
            REG_PREQ:   prdata = {24'd0, preq_reg};
            REG_PSUCC:  prdata = {24'd0, psucc_reg};
            default:    prdata = exp_reg;
        endcase
    end

    // effective register values
    logic [15:0] vol_e, rate_e, bms_e;
    logic [23:0] sleep_e;
    logic [7:0]  preq_e, psucc_e;
    logic [31:0] exp_e;
    logic [CW-1:0] nb_e;
    always_comb
    begin
        vol_e   = (vol_reg == 16'd0) ? 16'd1 : vol_reg;
        rate_e  = (rate_reg == 16'd0) ? 16'd1 : rate_reg;
        bms_e   = (bms_reg == 16'd0) ? 16'd1 : bms_reg;
        sleep_e = (sleep_reg == 24'd0) ? 24'd1 : sleep_reg;
        preq_e  = (preq_reg == 8'd0) ? 8'd1 : preq_reg;
        psucc_e = (psucc_reg == 8'd0) ? 8'd1 : psucc_reg;
        if (psucc_e > preq_e)
        begin
            psucc_e = preq_e;
        end
        exp_e   = (exp_reg == 32'd0) ? 32'd1 : exp_reg;
        if (bcnt_reg == 5'd0)
            nb_e = CW'(1);
        else if (32'(bcnt_reg) > MAX_BUCKETS)
            nb_e = CW'(MAX_BUCKETS);
        else
            nb_e = CW'(bcnt_reg);
    end

    // control and request registers
    logic [3:0]  st_reg, st_next;
    req_t        req_reg;
    logic [47:0] quo_reg;
    logic [16:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic [47:0] dvd_reg;
    logic [BW-1:0] slot_reg;
    logic [CW-1:0] idx_reg;
    logic [16:0] tot_reg, err_reg;
    logic [EW-1:0] eidx;
    logic        valid_reg [ENTRIES];
    logic [MAX_BUCKETS-1:0] bval_reg [ENTRIES];
    logic [1:0]  est_reg;
    logic [47:0] lchg_reg, lacc_reg;
    logic        out_valid_reg;
    rsp_t        rsp_reg;

    assign eidx      = EW'(req_reg.instance_index);
    assign in_stall  = (st_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_rsp   = rsp_reg;

    // entry memory: state, last change, last access
    logic        ent_we;
    logic [97:0] ent_wd, ent_rd;
    ercb_ram #(.WIDTH(98), .DEPTH(ENTRIES)) u_ent (
        .clk(clk), .we(ent_we), .waddr(eidx), .wdata(ent_wd),
        .raddr(eidx), .rdata(ent_rd)
    );

    // bucket memory: epoch, total, errors
    logic           bk_we;
    logic [KW-1:0]  bk_waddr, bk_raddr;
    logic [BDW-1:0] bk_wd, bk_rd;
    logic [BW-1:0]  bsel;
    ercb_ram #(.WIDTH(BDW), .DEPTH(NB)) u_bk (
        .clk(clk), .we(bk_we), .waddr(bk_waddr), .wdata(bk_wd),
        .raddr(bk_raddr), .rdata(bk_rd)
    );
    assign bsel = (st_reg == S_SUM || st_reg == S_SUMW) ? idx_reg[BW-1:0] : slot_reg;
    always_comb
    begin
        if (NB > MAX_BUCKETS)
            bk_raddr = KW'(32'(eidx) * MAX_BUCKETS + 32'(bsel));
        else
            bk_raddr = KW'(bsel);
    end
    logic bval_rd_reg;
    logic [KW-1:0] bk_raddr_q;
    logic [47:0] ep_rd;
    logic [15:0] bt_rd, be_rd;
    assign ep_rd = bval_rd_reg ? bk_rd[79:32] : 48'd0;
    assign bt_rd = bval_rd_reg ? bk_rd[31:16] : 16'd0;
    assign be_rd = bval_rd_reg ? bk_rd[15:0]  : 16'd0;

    // bit-serial divider step
    logic [16:0] rem_sh;
    assign rem_sh = {rem_reg[15:0], dvd_reg[47]};
    logic inrange;
    assign inrange = (32'(req_reg.instance_index) < ENTRIES);

    // modulo scratch: quo_reg holds quotient during S_DIV; mod uses dvd_reg
    logic [47:0] q_full_reg;
    logic        ev_invalid;
    assign ev_invalid = (req_reg.command == CMD_EVALUATE) && !valid_reg[eidx];

    // record update values
    logic [15:0] nt, ne;
    logic        same;
    assign same = (ep_rd == q_full_reg);
    always_comb
    begin
        nt = same ? bt_rd : 16'd0;
        ne = same ? be_rd : 16'd0;
        if (nt != SAT16) nt = nt + 16'd1;
        if (req_reg.call_failed && ne != SAT16) ne = ne + 16'd1;
    end

    logic [63:0] err_sh, rate_prod;
    logic        trip_q;
    logic [48:0] t_sleep, t_idle, t_exp;
    logic [30:0] idle_ms;
    assign idle_ms = 31'(sleep_e) * 31'(IDLE_FACTOR);
    assign t_sleep = 49'(lchg_reg) + 49'(sleep_e);
    assign t_idle  = 49'(lacc_reg) + 49'(idle_ms);
    assign t_exp   = 49'(lacc_reg) + 49'(exp_e);
    assign err_sh    = {32'd0, err_reg[15:0], 16'd0};
    assign rate_prod = 64'(rate_e) * 64'(tot_reg[15:0]);

    logic [15:0] t16, e16;
    assign t16 = tot_reg[15:0];
    assign e16 = err_reg[15:0];

    logic [1:0] nst;
    logic       chg_st, clr_bk;
    always_comb
    begin
        nst = est_reg; chg_st = 1'b0; clr_bk = 1'b0;
        case (est_reg)
            ST_OPEN:
            begin
                if (req_reg.half_open_enabled && t_sleep <= 49'(req_reg.now_ms))
                begin
                    nst = ST_HALF; chg_st = 1'b1; clr_bk = 1'b1;
                end
            end
            ST_CLOSED:
            begin
                if (t16 >= vol_e && trip_q)
                begin
                    nst = ST_OPEN; chg_st = 1'b1;
                end
            end
            default:
            begin
                if (t16 - e16 >= 16'(psucc_e))
                begin
                    nst = ST_CLOSED; chg_st = 1'b1; clr_bk = 1'b1;
                end
                else if (e16 > 16'(preq_e - psucc_e) || t_idle <= 49'(req_reg.now_ms))
                begin
                    nst = ST_OPEN; chg_st = 1'b1; clr_bk = 1'b1;
                end
            end
        endcase
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE:  if (in_valid && !out_valid_reg) st_next = S_DIV;
            S_DIV:   if (!inrange) st_next = S_OUT;
                     else if (cnt_reg == 6'd47) st_next = S_MOD;
            S_MOD:   if (cnt_reg == 6'd0) st_next = S_RDE;
            S_RDE:   st_next = S_ENT;
            S_ENT:   st_next = S_REC;
            S_REC:   st_next = S_SUM;
            S_SUM:   st_next = S_SUMW;
            S_SUMW:  st_next = (idx_reg == nb_e) ? S_DEC : S_SUM;
            S_DEC:   st_next = S_DEC2;
            S_DEC2:  st_next = S_OUT;
            S_OUT:   st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    // memory writes: bucket and access time on record, state on decision
    always_comb
    begin
        ent_we = 1'b0;
        ent_wd = {est_reg, lchg_reg, lacc_reg};
        bk_we = 1'b0;
        bk_waddr = bk_raddr_q;
        bk_wd = {q_full_reg, nt, ne};
        if (st_reg == S_REC && req_reg.command == CMD_RECORD)
        begin
            ent_we = 1'b1;
            ent_wd = {est_reg, lchg_reg, req_reg.now_ms};
            bk_we = 1'b1;
        end
        if (st_reg == S_DEC2 && !ev_invalid)
        begin
            ent_we = 1'b1;
            if (req_reg.command == CMD_EVALUATE)
            begin
                if (t_exp <= 49'(req_reg.now_ms))
                    ent_wd = {ST_CLOSED, 48'd0, 48'd0};
                else
                    ent_wd = {nst, chg_st ? req_reg.now_ms : lchg_reg, lacc_reg};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        trip_q <= (err_sh >= rate_prod);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
                bval_reg[i] <= '0;
            end
        end
        else
        begin
            st_reg <= st_next;
            if (out_valid_reg && !out_stall) out_valid_reg <= 1'b0;
            bval_rd_reg <= bval_reg[eidx][bsel] && valid_reg[eidx];
            bk_raddr_q <= bk_raddr;
            case (st_reg)
                S_IDLE:
                begin
                    if (in_valid && !out_valid_reg)
                    begin
                        req_reg <= in_req;
                        dvd_reg <= in_req.now_ms;
                        rem_reg <= 17'd0;
                        cnt_reg <= 6'd0;
                        quo_reg <= 48'd0;
                    end
                end
                S_DIV:
                begin
                    dvd_reg <= {dvd_reg[46:0], 1'b0};
                    if (rem_sh >= {1'b0, bms_e})
                    begin
                        rem_reg <= rem_sh - {1'b0, bms_e};
                        quo_reg <= {quo_reg[46:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[46:0], 1'b0};
                    end
                    cnt_reg <= (cnt_reg == 6'd47) ? 6'd48 : cnt_reg + 6'd1;
                    if (!inrange)
                    begin
                        rsp_reg <= '0;
                    end
                end
                S_MOD:
                begin
                    // quotient mod buckets by restoring division, 48 steps
                    if (cnt_reg == 6'd48)
                    begin
                        q_full_reg <= quo_reg;
                        dvd_reg <= quo_reg;
                        rem_reg <= 17'd0;
                        cnt_reg <= 6'd47;
                    end
                    else
                    begin
                        dvd_reg <= {dvd_reg[46:0], 1'b0};
                        if (rem_sh >= 17'(nb_e))
                            rem_reg <= rem_sh - 17'(nb_e);
                        else
                            rem_reg <= rem_sh;
                        cnt_reg <= cnt_reg - 6'd1;
                        if (cnt_reg == 6'd0)
                        begin
                            slot_reg <= BW'((rem_sh >= 17'(nb_e)) ? rem_sh - 17'(nb_e)
                                                                   : rem_sh);
                        end
                    end
                end
                S_ENT:
                begin
                    if (!valid_reg[eidx])
                    begin
                        est_reg <= ST_CLOSED; lchg_reg <= 48'd0; lacc_reg <= 48'd0;
                        if (req_reg.command == CMD_RECORD)
                        begin
                            valid_reg[eidx] <= 1'b1;
                            bval_reg[eidx] <= '0;
                        end
                    end
                    else
                    begin
                        est_reg <= ent_rd[97:96];
                        lchg_reg <= ent_rd[95:48];
                        lacc_reg <= ent_rd[47:0];
                    end
                end
                S_REC:
                begin
                    if (req_reg.command == CMD_RECORD)
                    begin
                        lacc_reg <= req_reg.now_ms;
                        bval_reg[eidx][slot_reg] <= 1'b1;
                    end
                    idx_reg <= '0;
                    tot_reg <= 17'd0;
                    err_reg <= 17'd0;
                end
                S_SUM:
                begin
                    idx_reg <= idx_reg + CW'(1);
                end
                S_SUMW:
                begin
                    if (49'(ep_rd) + 49'(nb_e) > 49'(q_full_reg))
                    begin
                        tot_reg <= (tot_reg + 17'(bt_rd) > 17'(SAT16)) ? 17'(SAT16)
                                   : tot_reg + 17'(bt_rd);
                        err_reg <= (err_reg + 17'(be_rd) > 17'(SAT16)) ? 17'(SAT16)
                                   : err_reg + 17'(be_rd);
                    end
                end
                S_DEC2:
                begin
                    if (req_reg.command == CMD_RECORD)
                    begin
                        rsp_reg <= {est_reg, 1'b0, 1'b0, t16, e16};
                    end
                    else if (ev_invalid)
                    begin
                        rsp_reg <= '0;
                    end
                    else if (t_exp <= 49'(req_reg.now_ms))
                    begin
                        rsp_reg <= {ST_CLOSED, est_reg != ST_CLOSED, 1'b1, 16'd0, 16'd0};
                        valid_reg[eidx] <= 1'b0;
                        bval_reg[eidx] <= '0;
                        est_reg <= ST_CLOSED;
                    end
                    else
                    begin
                        rsp_reg <= {nst, chg_st, 1'b0, t16, e16};
                        est_reg <= nst;
                        if (chg_st)
                            lchg_reg <= req_reg.now_ms;
                        if (clr_bk)
                            bval_reg[eidx] <= '0;
                    end
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end
endmodule

// ----- dv/tb_error_rate_circuit_breaker_unit.sv -----
// Testbench for the error-rate circuit breaker: scoreboard class, drivers, checks.
// Depends on ercb_pkg and error_rate_circuit_breaker_unit.
`timescale 1ns / 1ps

module tb_error_rate_circuit_breaker_unit;
    import ercb_pkg::*;

    localparam int NUM_ENTRIES = 16;
    localparam int NUM_BUCKETS = 16;
    localparam int LATENCY     = 52 + 2 * NUM_BUCKETS;
    localparam int IDLE_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 850;

    // Breaker predictor with its own copy of the table and registers
    class breaker_scoreboard;
        logic [15:0] volume, rate, bms;
        logic [4:0]  bcount;
        logic [23:0] sleep;
        logic [7:0]  preq, psucc;
        logic [31:0] expiry;
        bit          valid_q [NUM_ENTRIES];
        logic [1:0]  state_q [NUM_ENTRIES];
        logic [47:0] changed_at [NUM_ENTRIES];
        logic [47:0] accessed_at [NUM_ENTRIES];
        logic [47:0] epoch [NUM_ENTRIES][NUM_BUCKETS];
        int unsigned calls [NUM_ENTRIES][NUM_BUCKETS];
        int unsigned fails [NUM_ENTRIES][NUM_BUCKETS];
        rsp_t        pending[$];
        int          errors;

        function new();
            volume = 10; rate = 32768; bms = 1000; bcount = 10;
            sleep = 30000; preq = 10; psucc = 8; expiry = 3600000;
            errors = 0;
            for (int e = 0; e < NUM_ENTRIES; e++)
            begin
                valid_q[e] = 0; state_q[e] = ST_CLOSED;
                changed_at[e] = 0; accessed_at[e] = 0;
                wipe(e);
            end
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_VOLUME: volume = v[15:0];
                REG_RATE:   rate   = v[15:0];
                REG_BMS:    bms    = v[15:0];
                REG_BCOUNT: bcount = v[4:0];
                REG_SLEEP:  sleep  = v[23:0];
                REG_PREQ:   preq   = v[7:0];
                REG_PSUCC:  psucc  = v[7:0];
                default:    expiry = v;
            endcase
        endfunction

        function void wipe(int e);
            for (int i = 0; i < NUM_BUCKETS; i++)
            begin
                epoch[e][i] = 0; calls[e][i] = 0; fails[e][i] = 0;
            end
        endfunction

        function int unsigned nz(longint unsigned v);
            return (v == 0) ? 1 : int'(v);
        endfunction

        function int unsigned ring_len();
            int unsigned n;
            n = nz(bcount);
            return (n > NUM_BUCKETS) ? NUM_BUCKETS : n;
        endfunction

        // Saturating sums over live buckets
        function void window_sums(int e, logic [47:0] now, output int unsigned t,
                                  output int unsigned r);
            int unsigned n;
            longint unsigned cur;
            n = ring_len();
            cur = now / nz(bms);
            t = 0; r = 0;
            for (int i = 0; i < n; i++)
                if (longint'(epoch[e][i]) + n > cur)
                begin
                    t += calls[e][i]; r += fails[e][i];
                    if (t > 65535) t = 65535;
                    if (r > 65535) r = 65535;
                end
        endfunction

        function void note_request(req_t q);
            rsp_t o;
            int e;
            int unsigned t, r, pr, ps, k;
            longint unsigned cur, now;
            logic [1:0] st, prior;
            o = '0;
            e = q.instance_index;
            now = q.now_ms;
            if (q.command == CMD_RECORD)
            begin
                cur = now / nz(bms);
                k = cur % ring_len();
                if (!valid_q[e])
                begin
                    valid_q[e] = 1; state_q[e] = ST_CLOSED; changed_at[e] = 0; wipe(e);
                end
                accessed_at[e] = q.now_ms;
                if (epoch[e][k] != cur)
                begin
                    epoch[e][k] = cur; calls[e][k] = 0; fails[e][k] = 0;
                end
                if (calls[e][k] < 65535) calls[e][k]++;
                if (q.call_failed && fails[e][k] < 65535) fails[e][k]++;
                window_sums(e, q.now_ms, t, r);
                o.breaker_state = state_q[e];
                o.window_total = t; o.window_errors = r;
            end
            else if (valid_q[e])
            begin
                prior = state_q[e];
                st = prior;
                window_sums(e, q.now_ms, t, r);
                if (st == ST_OPEN)
                begin
                    if (q.half_open_enabled && longint'(changed_at[e]) + nz(sleep) <= now)
                    begin
                        st = ST_HALF; changed_at[e] = q.now_ms; wipe(e);
                    end
                end
                else if (st == ST_CLOSED)
                begin
                    if (t >= nz(volume) &&
                        (longint'(r) << 16) >= longint'(nz(rate)) * t)
                    begin
                        st = ST_OPEN; changed_at[e] = q.now_ms;
                    end
                end
                else
                begin
                    pr = nz(preq); ps = nz(psucc);
                    if (ps > pr) ps = pr;
                    if (t - r >= ps)
                    begin
                        st = ST_CLOSED; changed_at[e] = q.now_ms; wipe(e);
                    end
                    else if (r > pr - ps ||
                             longint'(accessed_at[e]) + 100 * longint'(nz(sleep)) <= now)
                    begin
                        st = ST_OPEN; changed_at[e] = q.now_ms; wipe(e);
                    end
                end
                state_q[e] = st;
                if (longint'(accessed_at[e]) + longint'(nz(expiry)) <= now)
                begin
                    valid_q[e] = 0; state_q[e] = ST_CLOSED;
                    changed_at[e] = 0; accessed_at[e] = 0; wipe(e);
                    st = ST_CLOSED; o.entry_expired = 1; t = 0; r = 0;
                end
                o.breaker_state = st;
                o.state_changed = (st != prior);
                o.window_total = t; o.window_errors = r;
            end
            pending.push_back(o);
        endfunction

        function void check_result(rsp_t got);
            rsp_t w;
            if (pending.size() == 0)
            begin
                $error("result with no request outstanding: %h", got);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.breaker_state !== w.breaker_state)
            begin
                $error("breaker_state exp %0d got %0d", w.breaker_state, got.breaker_state);
                errors++;
            end
            if (got.state_changed !== w.state_changed)
            begin
                $error("state_changed exp %0d got %0d", w.state_changed, got.state_changed);
                errors++;
            end
            if (got.entry_expired !== w.entry_expired)
            begin
                $error("entry_expired exp %0d got %0d", w.entry_expired, got.entry_expired);
                errors++;
            end
            if (got.window_total !== w.window_total)
            begin
                $error("window_total exp %0d got %0d", w.window_total, got.window_total);
                errors++;
            end
            if (got.window_errors !== w.window_errors)
            begin
                $error("window_errors exp %0d got %0d", w.window_errors, got.window_errors);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 0;
    logic        in_stall;
    req_t        in_req = '0;
    logic        out_valid;
    logic        out_stall = 0;
    rsp_t        out_rsp;

    breaker_scoreboard sb = new();
    bit          hold_off = 0;
    int          idle_cycles = 0;
    int          sent = 0;
    logic [47:0] clock_ms = 0;

    always #5 clk = ~clk;

    error_rate_circuit_breaker_unit DUT (.*);

    // Monitor: accepted requests feed the predictor, results get checked
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall) sb.note_request(in_req);
            if (out_valid && !out_stall) sb.check_result(out_rsp);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver stall pattern, with a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_off) out_stall <= 1;
        else
            case ($urandom_range(0, 3))
                0: out_stall <= ($urandom_range(0, 1) == 1);
                1: out_stall <= ($urandom_range(0, 7) == 0);
                default: out_stall <= 0;
            endcase
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] v);
        @(negedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
        @(negedge clk);
        penable <= 1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, v);
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // Offer one request and hold it until accepted
    task automatic send(logic cmd, logic [3:0] idx, logic [47:0] now, logic failed,
                        logic half_en);
        req_t q;
        q.command = cmd; q.instance_index = idx; q.now_ms = now;
        q.call_failed = failed; q.half_open_enabled = half_en;
        in_req <= q;
        in_valid <= 1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    // Random burst traffic; time creeps forward, mostly on few entries
    task automatic random_phase(int count);
        int burst;
        logic [3:0] idx;
        for (int i = 0; i < count; i++)
        begin
            burst = $urandom_range(1, 8);
            idx = (($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3)));
            case ($urandom_range(0, 9))
                0: clock_ms = clock_ms + $urandom_range(0, 100000);
                1: clock_ms = clock_ms + $urandom;
                2: clock_ms = clock_ms + 48'(longint'($urandom) << 16);
                default: clock_ms = clock_ms + $urandom_range(0, 400);
            endcase
            send(($urandom_range(0, 3) == 0) ? CMD_EVALUATE : CMD_RECORD, idx, clock_ms,
                 ($urandom_range(0, 2) != 0), ($urandom_range(0, 4) != 0));
            if (i % burst == 0 && $urandom_range(0, 2) == 0)
            begin
                in_valid <= 0;
                repeat ($urandom_range(1, 40)) @(negedge clk);
            end
        end
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // Directed: small window, fast trips, probes
        reg_write(REG_VOLUME, 2);
        reg_write(REG_RATE, 32768);
        reg_write(REG_BMS, 10);
        reg_write(REG_BCOUNT, 4);
        reg_write(REG_SLEEP, 50);
        reg_write(REG_PREQ, 3);
        reg_write(REG_PSUCC, 2);
        reg_write(REG_EXPIRY, 100000);
        send(CMD_EVALUATE, 4'd0, 48'd5, 0, 1);        // evaluate of invalid entry
        send(CMD_RECORD, 4'd0, 48'd10, 1, 0);
        send(CMD_RECORD, 4'd0, 48'd12, 1, 0);
        send(CMD_EVALUATE, 4'd0, 48'd15, 0, 1);       // trips open
        send(CMD_EVALUATE, 4'd0, 48'd30, 0, 0);       // half-open disabled
        send(CMD_EVALUATE, 4'd0, 48'd70, 0, 1);       // to half-open
        send(CMD_RECORD, 4'd0, 48'd71, 0, 0);
        send(CMD_RECORD, 4'd0, 48'd72, 0, 1);
        send(CMD_EVALUATE, 4'd0, 48'd73, 0, 1);       // closes
        send(CMD_RECORD, 4'd1, 48'd80, 1, 1);
        send(CMD_RECORD, 4'd1, 48'd81, 1, 1);
        send(CMD_EVALUATE, 4'd1, 48'd82, 1, 1);
        send(CMD_EVALUATE, 4'd1, 48'd200, 1, 1);      // half-open
        send(CMD_RECORD, 4'd1, 48'd201, 1, 0);
        send(CMD_RECORD, 4'd1, 48'd202, 1, 0);
        send(CMD_EVALUATE, 4'd1, 48'd203, 0, 1);      // too many errors, reopen
        send(CMD_RECORD, 4'd15, 48'hFFFF_FFFF_FFF0, 1, 1);
        send(CMD_EVALUATE, 4'd15, 48'hFFFF_FFFF_FFFF, 0, 1); // near top of time range, not expired
        send(CMD_RECORD, 4'd2, 48'd0, 0, 0);
        send(CMD_EVALUATE, 4'd2, 48'd40, 0, 0);       // stale window
        drain();

        // Zero registers and oversized counts, then a trip to open
        reg_write(REG_VOLUME, 0);
        reg_write(REG_RATE, 0);
        reg_write(REG_BMS, 0);
        reg_write(REG_BCOUNT, 31);
        reg_write(REG_SLEEP, 0);
        reg_write(REG_PREQ, 0);
        reg_write(REG_PSUCC, 255);
        reg_write(REG_EXPIRY, 0);
        send(CMD_RECORD, 4'd3, 48'd1000, 1, 1);
        send(CMD_EVALUATE, 4'd3, 48'd1000, 0, 1);
        drain();

        // Random phases across several settings
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    reg_write(REG_VOLUME, 3); reg_write(REG_RATE, 20000);
                    reg_write(REG_BMS, 100); reg_write(REG_BCOUNT, 8);
                    reg_write(REG_SLEEP, 2000); reg_write(REG_PREQ, 4);
                    reg_write(REG_PSUCC, 3); reg_write(REG_EXPIRY, 500000);
                end
                1:
                begin
                    reg_write(REG_VOLUME, 65535); reg_write(REG_RATE, 65535);
                    reg_write(REG_BMS, 65535); reg_write(REG_BCOUNT, 16);
                    reg_write(REG_SLEEP, 24'hFFFFFF); reg_write(REG_PREQ, 255);
                    reg_write(REG_PSUCC, 1); reg_write(REG_EXPIRY, 32'hFFFFFFFF);
                end
                2:
                begin
                    reg_write(REG_VOLUME, 1); reg_write(REG_RATE, 1);
                    reg_write(REG_BMS, 1); reg_write(REG_BCOUNT, 1);
                    reg_write(REG_SLEEP, 1); reg_write(REG_PREQ, 1);
                    reg_write(REG_PSUCC, 1); reg_write(REG_EXPIRY, 1);
                end
                default:
                begin
                    reg_write(REG_VOLUME, $urandom_range(1, 6));
                    reg_write(REG_RATE, $urandom_range(1, 65535));
                    reg_write(REG_BMS, $urandom_range(1, 300));
                    reg_write(REG_BCOUNT, $urandom_range(0, 31));
                    reg_write(REG_SLEEP, $urandom_range(1, 5000));
                    reg_write(REG_PREQ, $urandom_range(1, 12));
                    reg_write(REG_PSUCC, $urandom_range(1, 12));
                    reg_write(REG_EXPIRY, $urandom_range(1000, 2000000));
                end
            endcase
            if (ph == 3)
            begin
                // long receiver hold-off while the sender keeps offering
                fork
                    begin
                        hold_off = 1;
                        repeat (3000) @(posedge clk);
                        hold_off = 0;
                    end
                join_none
            end
            random_phase(RANDOM_ITEMS / 5);
            drain();
        end

        repeat (LATENCY) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/ercb_pkg.sv
hw/rtl/ercb_ram.sv
hw/rtl/error_rate_circuit_breaker_unit.sv
dv/tb_error_rate_circuit_breaker_unit.sv
